// ===== design/wtf_pkg.sv =====
`timescale 1ns / 1ps
package wtf_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_WIN_DEF     = 7;
  localparam int LINE_MAX_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths
  localparam int ROW_BITS     = 10;
  localparam int COL_BITS     = 16;
  localparam int MODE_BITS    = 3;
  localparam int WSZ_BITS     = 3;
  localparam int LEN_BITS     = 11;
  localparam int GCOL_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 16;

  // Operation codes
  localparam logic [MODE_BITS-1:0] MODE_TRI   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_TPI   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ROUGH = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MEAN  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_MIN   = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_MAX   = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WSIZE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NAN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GCOLS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACC,
    ST_DIVI,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic acc_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic cvalid;
    logic acc_last;
    logic need_div;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/wtf_ctrl.sv =====
`timescale 1ns / 1ps
module wtf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  wtf_pkg::status_t st,
  output wtf_pkg::cmd_t    cmd
);
  import wtf_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (!st.emit)        state_nxt = ST_IDLE;
        else if (!st.cvalid) state_nxt = ST_OUT;
        else                 state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (st.acc_last) state_nxt = st.need_div ? ST_DIVI : ST_OUT;
      end
      ST_DIVI: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== design/wtf_dp.sv =====
`timescale 1ns / 1ps
module wtf_dp #(
  parameter int MAX_WIN     = 7,
  parameter int LINE_MAX    = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wtf_pkg::cmd_t                        cmd,
  output wtf_pkg::status_t                     st,
  input  logic [wtf_pkg::MODE_BITS-1:0]        cfg_mode,
  input  logic [wtf_pkg::WSZ_BITS-1:0]         cfg_wsize,
  input  logic                                 cfg_nan,
  input  logic [wtf_pkg::LEN_BITS-1:0]         cfg_len,
  input  logic [wtf_pkg::GCOL_BITS-1:0]        cfg_gcols,
  input  logic [SAMPLE_BITS-1:0]               in_sample,
  input  logic                                 in_ok,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [SAMPLE_BITS-1:0]               out_value,
  output logic                                 out_ok,
  output logic [wtf_pkg::ROW_BITS-1:0]         out_row,
  output logic [wtf_pkg::COL_BITS-1:0]         out_col,
  output logic                                 out_last
);
  import wtf_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int SLOTS = MAX_WIN - 1;
  localparam int ABW   = $clog2(LINE_MAX);
  localparam int RCW   = $clog2(LINE_MAX + 1);
  localparam int WW    = $clog2(MAX_WIN + 1);
  localparam int IW    = $clog2(MAX_WIN);
  localparam int SLW   = $clog2(SLOTS);
  localparam int EW    = SB + 1;
  localparam int CW    = $clog2(MAX_WIN * MAX_WIN + 1);
  localparam int ACW   = SB + CW + 1;
  localparam int NW    = SB + CW + 2;
  localparam int DCW   = $clog2(NW + 1);
  localparam logic signed [NW:0] HI_W = (NW + 1)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [NW:0] LO_W = -HI_W - 1;

  // Line buffer rows: one slot per stored column
  logic [SLOTS-1:0][EW-1:0]   mem [LINE_MAX];
  logic [SLOTS-1:0][EW-1:0]   rd_r;
  logic [SLOTS-1:0][EW-1:0]   wr_row;
  logic [EW-1:0]              word_r;
  logic [ABW-1:0]             addr_r;

  // Window rows, newest row at index 0
  logic [MAX_WIN-1:0][EW-1:0] win_r [MAX_WIN];
  logic [MAX_WIN-1:0][EW-1:0] new_row;

  // Position counters
  logic [RCW-1:0]             row_r, row_nxt;
  logic [COL_BITS-1:0]        col_r, col_nxt;
  logic [SLW-1:0]             slot_r, slot_nxt;

  // Geometry
  logic [WW-1:0]              w_c, h_c;
  logic [RCW-1:0]             len_c;
  logic [COL_BITS-1:0]        gc_c;
  logic                       emit_c;
  logic [EW-1:0]              centre_w;
  logic                       cvalid_c;

  // Accumulators
  logic signed [SB-1:0]       centre_r, mn_r, mx_r;
  logic                       cvalid_r;
  logic signed [ACW-1:0]      sum_r, dsum_r, asum_r;
  logic [CW-1:0]              cnt_r;
  logic [IW-1:0]              ia_r, ik_r;
  logic [EW-1:0]              elem;
  logic                       elem_ok;
  logic signed [SB-1:0]       s_c;
  logic signed [SB:0]         d_c, ad_c;
  logic                       acc_last_c;

  // Divider
  logic [NW-1:0]              dq_r;
  logic [CW:0]                rem_r;
  logic [CW+1:0]              rem_sh;
  logic [CW+1:0]              rem_dif;
  logic [CW:0]                den;
  logic                       dneg_r;
  logic [DCW-1:0]             dcnt_r;
  logic signed [ACW-1:0]      num_c;
  logic [ACW-1:0]             mag_c;

  // Result
  logic signed [NW:0]         q_s, rng_s;
  logic [SB-1:0]              res_c;
  logic [ROW_BITS-1:0]        orow_r;
  logic [COL_BITS-1:0]        ocol_r;
  logic                       olast_r;
  logic                       out_valid_r;

  function automatic logic [SB-1:0] sat_w(input logic signed [NW:0] v);
    if (v > HI_W)      sat_w = HI_W[SB-1:0];
    else if (v < LO_W) sat_w = LO_W[SB-1:0];
    else               sat_w = v[SB-1:0];
  endfunction

  // Clamp the window size, column length and grid width
  always_comb begin
    int wi, li, gi;
    wi = int'(cfg_wsize);
    if (!cfg_wsize[0]) wi = (wi == 0) ? 0 : wi - 1;
    if (wi < 3) wi = 3;
    if (wi > MAX_WIN) wi = MAX_WIN;
    w_c = WW'(wi);
    h_c = w_c >> 1;
    li = int'(cfg_len);
    if (li < 2) li = 2;
    if (li > LINE_MAX) li = LINE_MAX;
    len_c = RCW'(li);
    gi = int'(cfg_gcols);
    if (gi < 2) gi = 2;
    gc_c = COL_BITS'(gi);
  end

  assign emit_c = (int'(row_r) >= int'(w_c) - 1) && (int'(col_r) >= int'(w_c) - 1) &&
                  (row_r < len_c) && (col_r < gc_c);

  // Centre after the shift: the row now one above it
  assign centre_w = win_r[IW'(h_c - 1'b1)][IW'(h_c)];
  assign cvalid_c = !cfg_nan || centre_w[SB];

  // Merge the new sample into its slot and pick the new window row
  always_comb begin
    int t;
    for (int j = 0; j < SLOTS; j++) begin
      wr_row[j] = (SLW'(j) == slot_r) ? word_r : rd_r[j];
    end
    new_row[0] = word_r;
    for (int k = 1; k < MAX_WIN; k++) begin
      t = int'(slot_r) - k;
      if (t < 0) t = t + SLOTS;
      new_row[k] = rd_r[SLW'(t)];
    end
  end

  // Line buffer read on accept, write back on load
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r <= {in_ok, in_sample};
      addr_r <= row_r[ABW-1:0];
      rd_r   <= mem[row_r[ABW-1:0]];
    end
    if (cmd.load) begin
      mem[addr_r] <= wr_row;
    end
  end

  // Shift the window by one row
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = MAX_WIN - 1; a > 0; a--) begin
        win_r[a] <= win_r[a - 1];
      end
      win_r[0] <= new_row;
    end
  end

  // Advance row and column
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (int'(row_r) + 1 >= int'(len_c)) begin
      row_nxt = '0;
      if (int'(col_r) + 1 >= int'(gc_c)) begin
        col_nxt  = '0;
        slot_nxt = '0;
      end else begin
        col_nxt  = col_r + 1'b1;
        slot_nxt = (int'(slot_r) == SLOTS - 1) ? '0 : slot_r + 1'b1;
      end
    end else begin
      row_nxt = row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cmd.load) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // One window element per step
  assign elem       = win_r[ia_r][ik_r];
  assign elem_ok    = !cfg_nan || elem[SB];
  assign s_c        = signed'(elem[SB-1:0]);
  assign d_c        = (SB + 1)'(centre_r) - (SB + 1)'(s_c);
  assign ad_c       = (d_c < 0) ? -d_c : d_c;
  assign acc_last_c = (int'(ia_r) == int'(w_c) - 1) && (int'(ik_r) == int'(w_c) - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      orow_r   <= ROW_BITS'(int'(row_r) - int'(h_c));
      ocol_r   <= COL_BITS'(int'(col_r) - int'(h_c));
      olast_r  <= (int'(row_r) == int'(len_c) - 1) && (int'(col_r) == int'(gc_c) - 1);
      centre_r <= signed'(centre_w[SB-1:0]);
      mn_r     <= signed'(centre_w[SB-1:0]);
      mx_r     <= signed'(centre_w[SB-1:0]);
      cvalid_r <= cvalid_c;
      sum_r    <= '0;
      dsum_r   <= '0;
      asum_r   <= '0;
      cnt_r    <= '0;
      ia_r     <= '0;
      ik_r     <= '0;
    end else if (cmd.acc_step) begin
      if (elem_ok) begin
        sum_r  <= sum_r + ACW'(s_c);
        dsum_r <= dsum_r + ACW'(d_c);
        asum_r <= asum_r + ACW'(ad_c);
        cnt_r  <= cnt_r + 1'b1;
        if (s_c < mn_r) mn_r <= s_c;
        if (s_c > mx_r) mx_r <= s_c;
      end
      if (int'(ik_r) == int'(w_c) - 1) begin
        ik_r <= '0;
        ia_r <= ia_r + 1'b1;
      end else begin
        ik_r <= ik_r + 1'b1;
      end
    end
  end

  // Pick the numerator for the rounding divide
  always_comb begin
    unique case (cfg_mode)
      MODE_TRI: num_c = asum_r;
      MODE_TPI: num_c = dsum_r;
      default:  num_c = sum_r;
    endcase
    mag_c = (num_c < 0) ? ACW'(-num_c) : ACW'(num_c);
  end

  // Restoring divide of (2|n| + cnt) by 2 cnt, one bit a step
  assign den     = {cnt_r, 1'b0};
  assign rem_sh  = {rem_r, dq_r[NW-1]};
  assign rem_dif = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r   <= (NW'(mag_c) << 1) + NW'(cnt_r);
      rem_r  <= '0;
      dneg_r <= num_c < 0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_r <= rem_dif[CW:0];
        dq_r  <= {dq_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[CW:0];
        dq_r  <= {dq_r[NW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Select and saturate the result
  always_comb begin
    q_s   = dneg_r ? -signed'({1'b0, dq_r}) : signed'({1'b0, dq_r});
    rng_s = (NW + 1)'(mx_r) - (NW + 1)'(mn_r);
    if (!cvalid_r) begin
      res_c = centre_r;
    end else begin
      unique case (cfg_mode)
        MODE_TRI, MODE_TPI, MODE_MEAN: res_c = sat_w(q_s);
        MODE_ROUGH:                    res_c = sat_w(rng_s);
        MODE_MIN:                      res_c = mn_r;
        MODE_MAX:                      res_c = mx_r;
        default:                       res_c = centre_r;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= res_c;
      out_ok    <= cvalid_r;
      out_row   <= orow_r;
      out_col   <= ocol_r;
      out_last  <= olast_r;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign st.emit     = emit_c;
  assign st.cvalid   = cvalid_c;
  assign st.acc_last = acc_last_c;
  assign st.need_div = (cfg_mode == MODE_TRI) || (cfg_mode == MODE_TPI) ||
                       (cfg_mode == MODE_MEAN);
  assign st.div_last = (int'(dcnt_r) == NW - 1);
  assign st.out_free = !out_valid_r || out_tready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a waiting item");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_step |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1))
    else $error("sample count jumped");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> cnt_r != '0)
    else $error("divide by zero count");

endmodule

// ===== design/window_terrain_filter.sv =====
`timescale 1ns / 1ps
// Each accepted item reads its line buffer row and is then loaded into the window; an item
// with no result goes straight back to idle. A result for roughness/min/max scans the window
// (one element a cycle); TRI, TPI and mean then also run the bit-serial divider. An invalid
// centre with NaN checking on skips the scan. A result then waits for a free output register.
// The next item is accepted only once the last is through; the output register frees it.
// Reset (rst_n, synchronous, active low) clears the counters and the output valid and
// returns the config registers to their defaults.
module window_terrain_filter #(
  parameter int MAX_WIN     = wtf_pkg::MAX_WIN_DEF,
  parameter int LINE_MAX    = wtf_pkg::LINE_MAX_DEF,
  parameter int SAMPLE_BITS = wtf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,  // sample
  input  logic                                   in_tuser,  // sample_ok
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // value, row, column
  output logic [((SAMPLE_BITS+wtf_pkg::ROW_BITS+wtf_pkg::COL_BITS+7)/8)*8-1:0] out_tdata,
  output logic                                   out_tuser, // value_ok
  output logic                                   out_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [wtf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [wtf_pkg::CFG_DAT_BITS-1:0]       cfg_data
);
  import wtf_pkg::*;

  localparam int ODW = ((SAMPLE_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8;

  logic [MODE_BITS-1:0] mode_r;
  logic [WSZ_BITS-1:0]  wsize_r;
  logic                 nan_r;
  logic [LEN_BITS-1:0]  len_r;
  logic [GCOL_BITS-1:0] gcols_r;
  cmd_t                 cmd;
  status_t              st;
  logic [SAMPLE_BITS-1:0] o_value;
  logic [ROW_BITS-1:0]  o_row;
  logic [COL_BITS-1:0]  o_col;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TPI;
      wsize_r <= WSZ_BITS'(3);
      nan_r   <= 1'b0;
      len_r   <= LEN_BITS'(1024);
      gcols_r <= GCOL_BITS'(1024);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[MODE_BITS-1:0];
        REG_WSIZE: wsize_r <= cfg_data[WSZ_BITS-1:0];
        REG_NAN:   nan_r   <= cfg_data[0];
        REG_LEN:   len_r   <= cfg_data[LEN_BITS-1:0];
        REG_GCOLS: gcols_r <= cfg_data[GCOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  wtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  wtf_dp #(
    .MAX_WIN     (MAX_WIN),
    .LINE_MAX    (LINE_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_mode   (mode_r),
    .cfg_wsize  (wsize_r),
    .cfg_nan    (nan_r),
    .cfg_len    (len_r),
    .cfg_gcols  (gcols_r),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_ok      (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_value  (o_value),
    .out_ok     (out_tuser),
    .out_row    (o_row),
    .out_col    (o_col),
    .out_last   (out_tlast)
  );

  assign out_tdata = ODW'({o_col, o_row, o_value});

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import wtf_pkg::*;

  localparam int SBITS    = SAMPLE_BITS_DEF;
  localparam int WMAX     = MAX_WIN_DEF;
  localparam int LMAX     = LINE_MAX_DEF;
  localparam int SLOTS    = WMAX - 1;
  localparam int OUT_W    = ((SBITS + ROW_BITS + COL_BITS + 7) / 8) * 8;
  localparam int IDLE_MAX = 20000;
  localparam int DRAIN    = 150;

  typedef struct {
    logic [SBITS-1:0]    value;
    logic                value_ok;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] column;
    logic                last;
  } terrain_res_t;

  // Terrain window predictor with its own line buffers and expected-result queue
  class terrain_scoreboard;
    logic [SBITS:0]  col_buf[SLOTS*LMAX];
    logic [SBITS:0]  win[WMAX][WMAX];
    int unsigned     row_cnt, col_cnt;
    logic [2:0]      op, wsize;
    logic            nan_on;
    int unsigned     len, gcols;
    terrain_res_t    pending[$];
    int              errors, results_seen, items_seen;

    function new();
      foreach (col_buf[i]) col_buf[i] = '0;
      foreach (win[a, k]) win[a][k] = '0;
      row_cnt = 0; col_cnt = 0;
      op = MODE_TPI; wsize = 3'd3; nan_on = 1'b0; len = 1024; gcols = 1024;
      errors = 0; results_seen = 0; items_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] d);
      case (idx)
        REG_MODE:  op = d[2:0];
        REG_WSIZE: wsize = d[2:0];
        REG_NAN:   nan_on = d[0];
        REG_LEN:   len = 32'(d[10:0]);
        REG_GCOLS: gcols = 32'(d);
        default: ;
      endcase
    endfunction

    function longint sext(logic [SBITS-1:0] raw);
      return longint'($signed(raw));
    endfunction

    function longint clip(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SBITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // round to nearest, halves away from zero
    function longint div_near(longint n, longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
    endfunction

    function void note_item(logic [SBITS-1:0] smp, logic ok);
      logic [SBITS:0] word, e;
      int unsigned    r, c, w, h, l, g;
      bit             emit, cvalid;
      longint         centre, result, sum, asum, cnt, mn, mx, s;
      terrain_res_t   res;
      word = {ok, smp};
      r = row_cnt % LMAX;
      c = col_cnt;
      items_seen++;
      // shift the window down one row and fetch the new row
      for (int a = WMAX - 1; a > 0; a--)
        for (int k = 0; k < WMAX; k++) win[a][k] = win[a-1][k];
      win[0][0] = word;
      for (int k = 1; k < WMAX; k++)
        win[0][k] = col_buf[r*SLOTS + ((c % SLOTS) + 2*SLOTS - k) % SLOTS];
      col_buf[r*SLOTS + c % SLOTS] = word;
      w = wsize;
      if (w % 2 == 0) w = (w != 0) ? w - 1 : 0;
      if (w < 3) w = 3;
      if (w > WMAX) w = WMAX;
      h = w / 2;
      l = (len < 2) ? 2 : ((len > LMAX) ? LMAX : len);
      g = (gcols < 2) ? 2 : gcols;
      emit = row_cnt >= w - 1 && col_cnt >= w - 1 && row_cnt < l && col_cnt < g;
      if (emit) begin
        centre = sext(win[h][h][SBITS-1:0]);
        cvalid = !nan_on || win[h][h][SBITS];
        result = centre;
        sum = 0; asum = 0; cnt = 0; mn = centre; mx = centre;
        if (cvalid) begin
          for (int a = 0; a < w; a++)
            for (int k = 0; k < w; k++) begin
              e = win[a][k];
              if (!(nan_on && !e[SBITS])) begin
                s = sext(e[SBITS-1:0]);
                sum += s;
                asum += (centre > s) ? centre - s : s - centre;
                cnt++;
                if (s < mn) mn = s;
                if (s > mx) mx = s;
              end
            end
          case (op)
            MODE_TRI:   result = div_near(asum, cnt);
            MODE_TPI:   result = div_near(centre * cnt - sum, cnt);
            MODE_ROUGH: result = mx - mn;
            MODE_MEAN:  result = div_near(sum, cnt);
            MODE_MIN:   result = mn;
            MODE_MAX:   result = mx;
            default:    result = centre;
          endcase
          result = clip(result);
        end
        res.value = result[SBITS-1:0];
        res.value_ok = cvalid;
        res.row = ROW_BITS'(row_cnt - h);
        res.column = COL_BITS'(col_cnt - h);
        res.last = (row_cnt == l - 1) && (col_cnt == g - 1);
        pending.push_back(res);
      end
      row_cnt++;
      if (row_cnt >= l) begin
        row_cnt = 0;
        col_cnt++;
        if (col_cnt >= g) col_cnt = 0;
      end
    endfunction

    function void check_result(terrain_res_t got);
      terrain_res_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h ok=%b row=%0d col=%0d last=%b", $realtime,
                 got.value, got.value_ok, got.row, got.column, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value expected %h actual %h", $realtime, want.value, got.value);
        errors++;
      end
      if (got.value_ok !== want.value_ok) begin
        $display("%0t: value_ok expected %b actual %b", $realtime, want.value_ok, got.value_ok);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: row expected %0d actual %0d", $realtime, want.row, got.row);
        errors++;
      end
      if (got.column !== want.column) begin
        $display("%0t: column expected %0d actual %0d", $realtime, want.column, got.column);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $realtime, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk, rst_n;
  logic                    in_tvalid, in_tready, in_tuser;
  logic [SBITS-1:0]        in_tdata;
  logic                    out_tvalid, out_tready, out_tuser, out_tlast;
  logic [OUT_W-1:0]        out_tdata;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DAT_BITS-1:0] cfg_data;

  terrain_scoreboard sb;
  int unsigned       cyc;
  int unsigned       idle_cycles;
  int unsigned       phases_run;

  window_terrain_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: count cycles with no handshake on any channel
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: check at the rising edge, change ready at the falling edge
  initial begin
    terrain_res_t got;
    int unsigned  pat, hold;
    pat = 0; hold = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[SBITS-1:0];
        got.row = out_tdata[SBITS +: ROW_BITS];
        got.column = out_tdata[SBITS+ROW_BITS +: COL_BITS];
        got.value_ok = out_tuser;
        got.last = out_tlast;
        sb.check_result(got);
      end
      @(negedge clk);
      // hold off once for a long stretch so the block backs up its input
      if (cyc == 6000) hold = 500;
      if (cyc % 300 == 0) pat = $urandom_range(0, 3);
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else begin
        case (pat)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: out_tready = (cyc % 7) != 0;
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [SBITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SBITS-1){1'b1}}};
      1: return {1'b1, {(SBITS-1){1'b0}}};
      2, 3, 4: return SBITS'($urandom_range(0, 4000)) - SBITS'(2000);
      default: return SBITS'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Feed a whole grid so the counters come back to zero at its end
  task automatic stream_grid(int unsigned n, bit nan_heavy);
    int unsigned left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        in_tvalid = 1'b1;
        in_tdata = pick_sample();
        in_tuser = nan_heavy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) != 0);
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        sb.note_item(in_tdata, in_tuser);
        @(negedge clk);
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic run_phase(logic [2:0] op, logic [2:0] ws, logic nan, int unsigned l,
                           int unsigned g);
    int unsigned le, ge;
    write_reg(REG_MODE, CFG_DAT_BITS'(op));
    write_reg(REG_WSIZE, CFG_DAT_BITS'(ws));
    write_reg(REG_NAN, CFG_DAT_BITS'(nan));
    write_reg(REG_LEN, CFG_DAT_BITS'(l));
    write_reg(REG_GCOLS, CFG_DAT_BITS'(g));
    le = (l < 2) ? 2 : ((l > LMAX) ? LMAX : l);
    ge = (g < 2) ? 2 : g;
    stream_grid(le * ge, 1'($urandom_range(0, 1)));
    wait_drained();
    phases_run++;
  endtask

  initial begin
    sb = new();
    cyc = 0; idle_cycles = 0; phases_run = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Directed: every operation, undefined modes, clamped sizes and lengths
    run_phase(MODE_TRI,   3'd3, 1'b0, 4, 3);
    run_phase(MODE_TPI,   3'd7, 1'b1, 8, 7);
    run_phase(MODE_ROUGH, 3'd4, 1'b1, 5, 4);
    run_phase(MODE_MEAN,  3'd5, 1'b0, 6, 5);
    run_phase(MODE_MIN,   3'd0, 1'b1, 0, 0);
    run_phase(MODE_MAX,   3'd1, 1'b1, 1, 1);
    run_phase(3'd6,       3'd6, 1'b1, 5, 4);
    run_phase(3'd7,       3'd2, 1'b0, 3, 3);
    run_phase(MODE_ROUGH, 3'd3, 1'b1, 300, 3);

    // Random grids, mostly small enough to produce results
    while (sb.items_seen < 1900)
      run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 14), $urandom_range(0, 10));

    wait_drained();
    $display("Covered %0d grids, %0d samples and %0d window results across all modes",
             phases_run, sb.items_seen, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
